/* rtl/fdf_pkg.sv */
`default_nettype none

package fdf_pkg;

    localparam logic [7:0] START_BYTE     = 8'hF0;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h02;
    localparam logic [7:0] TYPE_SWITCH    = 8'h03;
    localparam logic [7:0] SUB_KEY        = 8'h81;
    localparam logic [7:0] SUB_PEDAL      = 8'h82;
    localparam logic [7:0] SUB_HB_ONE     = 8'h90;
    localparam logic [7:0] SUB_HB_TWO     = 8'h30;
    localparam logic [7:0] VAL_RELEASED   = 8'h00;
    localparam logic [7:0] VAL_PRESSED    = 8'h01;

    localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [1:0] KIND_CTRL      = 2'd1;
    localparam logic [1:0] KIND_PRESSED   = 2'd2;
    localparam logic [1:0] KIND_RELEASED  = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] id;
        logic [7:0] value;
    } t_event;

endpackage

`default_nettype wire

/* rtl/footswitch_packet_deframer_unit.sv */
`default_nettype none

// Packet deframer for a foot-controller serial link. Each input item is one
// received byte; a complete heartbeat, control change, key press or key
// release packet produces one event item, other bytes produce none. One byte
// is accepted every cycle while o_stall is low; the framing state is updated
// in the same cycle the byte is taken, and the event is registered into the
// output register, or into the skid register behind it while the output is
// stalled. That skid register lets input continue for one event while the
// output is stalled; o_stall rises only when the skid register is also occupied.

module footswitch_packet_deframer_unit
    import fdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_event_kind,
    output logic [7:0]      o_event_id,
    output logic [7:0]      o_event_value
);

    logic   accept;
    logic   out_free;
    t_event core_event;
    logic   r_out_valid;
    t_event r_out;
    logic   r_skid_valid;
    t_event r_skid;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    fdf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_event   (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // While the skid register is full no byte is accepted, so it
            // drains before any new event can arrive.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= core_event.valid;
            end
        end else if (core_event.valid) begin
            r_skid_valid <= 1'b1;
        end
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : core_event;
        end else if (core_event.valid) begin
            r_skid <= core_event;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_out.kind;
    assign o_event_id    = r_out.id;
    assign o_event_value = r_out.value;

endmodule

`default_nettype wire

/* rtl/fdf_core.sv */
`default_nettype none

module fdf_core
    import fdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    output t_event          o_event
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_TYPE,
        S_SUB,
        S_ID,
        S_LAST
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic       r_long;
    logic       n_long;
    logic [7:0] r_subtype;
    logic [7:0] n_subtype;
    logic [7:0] r_id;
    logic [7:0] n_id;
    logic       sub_ok;

    assign sub_ok = (i_rx_byte == SUB_KEY) || (i_rx_byte == SUB_PEDAL) ||
                    (i_rx_byte == SUB_HB_ONE) || (i_rx_byte == SUB_HB_TWO);

    always_comb begin
        n_state   = r_state;
        n_long    = r_long;
        n_subtype = r_subtype;
        n_id      = r_id;
        o_event   = '0;
        unique case (r_state)
            S_WAIT: begin
                if (i_rx_byte == START_BYTE) begin
                    n_state = S_TYPE;
                end
            end
            S_TYPE: begin
                // A bad type byte drops the packet and is not taken as a new start.
                if (i_rx_byte == TYPE_HEARTBEAT) begin
                    n_long  = 1'b0;
                    n_state = S_SUB;
                end else if (i_rx_byte == TYPE_SWITCH) begin
                    n_long  = 1'b1;
                    n_state = S_SUB;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_SUB: begin
                if (sub_ok) begin
                    n_subtype = i_rx_byte;
                    n_state   = S_ID;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_ID: begin
                n_id = i_rx_byte;
                if (r_long) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_WAIT;
                    if (r_subtype == SUB_HB_TWO) begin
                        o_event.valid = 1'b1;
                        o_event.kind  = KIND_HEARTBEAT;
                    end
                end
            end
            S_LAST: begin
                n_state    = S_WAIT;
                o_event.id = r_id;
                if (r_subtype == SUB_PEDAL) begin
                    o_event.valid = 1'b1;
                    o_event.kind  = KIND_CTRL;
                    o_event.value = i_rx_byte;
                end else if (r_subtype == SUB_KEY && i_rx_byte == VAL_RELEASED) begin
                    o_event.valid = 1'b1;
                    o_event.kind  = KIND_RELEASED;
                end else if (r_subtype == SUB_KEY && i_rx_byte == VAL_PRESSED) begin
                    o_event.valid = 1'b1;
                    o_event.kind  = KIND_PRESSED;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
        if (!i_accept) begin
            o_event.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_long  <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_long  <= n_long;
        end
        if (i_accept) begin
            r_subtype <= n_subtype;
            r_id      <= n_id;
        end
    end

endmodule

`default_nettype wire
